FILE: hw/rtl/desks_pkg.sv
package desks_pkg;

	localparam int HalfBits = 28;
	localparam int CdBits   = 2 * HalfBits;
	localparam int KeyBits  = 64;
	localparam int SubBits  = 48;
	localparam int Rounds   = 16;
	localparam int RoundW   = $clog2(Rounds);
	localparam int KeyIdxW  = $clog2(KeyBits);
	localparam int CdIdxW   = $clog2(CdBits);
	localparam int SubIdxW  = $clog2(SubBits);

	typedef logic [HalfBits-1:0] half_t;
	typedef logic [CdBits-1:0]   cd_t;
	typedef logic [SubBits-1:0]  subkey_t;
	typedef logic [RoundW-1:0]   round_t;

	localparam round_t LastRound = round_t'(Rounds - 1);

	// FIPS 46-3 tables, entry 1 = MSB of the source
	localparam logic [6:0] Pc1Table [CdBits] = '{
		7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50, 7'd42, 7'd34,
		7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
		7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,
		7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
		7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
	};

	localparam logic [6:0] Pc2Table [SubBits] = '{
		7'd14, 7'd17, 7'd11, 7'd24, 7'd1,  7'd5,  7'd3,  7'd28, 7'd15, 7'd6,  7'd21, 7'd10,
		7'd23, 7'd19, 7'd12, 7'd4,  7'd26, 7'd8,  7'd16, 7'd7,  7'd27, 7'd20, 7'd13, 7'd2,
		7'd41, 7'd52, 7'd31, 7'd37, 7'd47, 7'd55, 7'd30, 7'd40, 7'd51, 7'd45, 7'd33, 7'd48,
		7'd44, 7'd49, 7'd39, 7'd56, 7'd34, 7'd53, 7'd46, 7'd42, 7'd50, 7'd36, 7'd29, 7'd32
	};

	function automatic cd_t pc1(input logic [KeyBits-1:0] key);
		cd_t res;
		res = '0;
		for (int i = 0; i < CdBits; i++) begin
			res[CdIdxW'(CdBits-1-i)] = key[KeyIdxW'(KeyBits - int'(Pc1Table[i]))];
		end
		return res;
	endfunction

	function automatic subkey_t pc2(input cd_t cd);
		subkey_t res;
		res = '0;
		for (int i = 0; i < SubBits; i++) begin
			res[SubIdxW'(SubBits-1-i)] = cd[CdIdxW'(CdBits - int'(Pc2Table[i]))];
		end
		return res;
	endfunction

	// rounds 1, 2, 9 and 16 rotate by one, the rest by two
	function automatic logic shift_one(input round_t r);
		return (r == round_t'(0)) || (r == round_t'(1)) || (r == round_t'(8)) ||
			(r == LastRound);
	endfunction

endpackage

FILE: hw/rtl/desks_round.sv
module desks_round (
	input  desks_pkg::cd_t     cd,
	input  desks_pkg::round_t  round_num,
	output desks_pkg::cd_t     cd_next,
	output desks_pkg::subkey_t subkey
);

	desks_pkg::half_t c, d, c_rot, d_rot;

	assign c = cd[desks_pkg::CdBits-1:desks_pkg::HalfBits];
	assign d = cd[desks_pkg::HalfBits-1:0];

	always_comb begin
		if (desks_pkg::shift_one(round_num)) begin
			c_rot = {c[desks_pkg::HalfBits-2:0], c[desks_pkg::HalfBits-1]};
			d_rot = {d[desks_pkg::HalfBits-2:0], d[desks_pkg::HalfBits-1]};
		end else begin
			c_rot = {c[desks_pkg::HalfBits-3:0], c[desks_pkg::HalfBits-1 -: 2]};
			d_rot = {d[desks_pkg::HalfBits-3:0], d[desks_pkg::HalfBits-1 -: 2]};
		end
	end

	assign cd_next = {c_rot, d_rot};
	assign subkey  = desks_pkg::pc2(cd_next);

endmodule

FILE: hw/rtl/des_key_schedule.sv
// DES key schedule.
// Key channel: key with key_valid / key_stall. A key is taken when key_valid
// is high and key_stall is low; PC-1 is applied as it is registered.
// Subkey channel: round_index, subkey, last with subkey_valid / subkey_stall.
// Each key yields sixteen transactions in round order, last set on round 16.
// The key is registered with PC-1 applied; each subkey is then registered in the
// output from C/D, one subkey per cycle while the receiver does not stall.
// Keys go one at a time through the single round unit, which rotates C/D and
// applies PC-2 once per cycle unless the subkey side stalls. The next key is
// taken in the cycle the sixteenth subkey is produced, so keys run back to back.
// A stall on the subkey side holds the output register and freezes the round
// unit; key_stall stays high until the current key's last round is produced.
// Reset clears the busy flag and the output valid; no key is in progress.
module des_key_schedule (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     key_valid,
	output logic                     key_stall,
	input  logic [63:0]              key,
	output logic                     subkey_valid,
	input  logic                     subkey_stall,
	output logic [3:0]               round_index,
	output logic [47:0]              subkey,
	output logic                     last
);

	desks_pkg::cd_t     cd_q, cd_next;
	desks_pkg::round_t  round_q;
	desks_pkg::subkey_t subkey_next;
	logic               busy_q;
	logic               out_free, gen, key_take, gen_last;

	desks_round u_round (
		.cd       (cd_q),
		.round_num(round_q),
		.cd_next  (cd_next),
		.subkey   (subkey_next)
	);

	assign out_free  = !subkey_valid || !subkey_stall;
	assign gen       = busy_q && out_free;
	assign gen_last  = gen && (round_q == desks_pkg::LastRound);
	assign key_stall = busy_q && !gen_last;
	assign key_take  = key_valid && !key_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			round_q <= '0;
		end else if (key_take) begin
			busy_q  <= 1'b1;
			round_q <= '0;
		end else if (gen) begin
			busy_q  <= !gen_last;
			round_q <= round_q + desks_pkg::round_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (key_take) begin
			cd_q <= desks_pkg::pc1(key);
		end else if (gen) begin
			cd_q <= cd_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subkey_valid <= 1'b0;
		end else if (out_free) begin
			subkey_valid <= gen;
		end
	end

	always_ff @(posedge clk) begin
		if (gen) begin
			round_index <= round_q;
			subkey      <= subkey_next;
			last        <= (round_q == desks_pkg::LastRound);
		end
	end

	a_last_round: assert property (@(posedge clk) disable iff (!arst_n)
		subkey_valid && last |-> round_index == desks_pkg::LastRound)
		else $error("last flag on a round other than sixteen");

	a_take_starts: assert property (@(posedge clk) disable iff (!arst_n)
		key_take |=> busy_q && round_q == '0)
		else $error("accepted key did not start at round one");

	a_gen_shows: assert property (@(posedge clk) disable iff (!arst_n)
		gen |=> subkey_valid && round_index == $past(round_q))
		else $error("produced subkey not presented");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !key_stall)
		else $error("key stalled while idle");

	a_run_done: assert property (@(posedge clk) disable iff (!arst_n)
		gen_last && !key_take |=> !busy_q)
		else $error("busy after round sixteen");

endmodule

FILE: verif/des_subkey_checker.sv
`timescale 1ns / 100ps

module des_subkey_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        key_valid,
	input  logic        key_stall,
	input  logic [63:0] key,
	input  logic        subkey_valid,
	input  logic        subkey_stall,
	input  logic [3:0]  round_index,
	input  logic [47:0] subkey,
	input  logic        last,
	output int          fail_count,
	output int          outstanding
);

	localparam int Rounds = 16;
	localparam int MaxReports = 10;

	// entries count from 1 = MSB of the source word
	localparam int Pc1Pick [0:55] = '{
		57, 49, 41, 33, 25, 17,  9,  1, 58, 50, 42, 34, 26, 18,
		10,  2, 59, 51, 43, 35, 27, 19, 11,  3, 60, 52, 44, 36,
		63, 55, 47, 39, 31, 23, 15,  7, 62, 54, 46, 38, 30, 22,
		14,  6, 61, 53, 45, 37, 29, 21, 13,  5, 28, 20, 12,  4
	};

	localparam int Pc2Pick [0:47] = '{
		14, 17, 11, 24,  1,  5,  3, 28, 15,  6, 21, 10,
		23, 19, 12,  4, 26,  8, 16,  7, 27, 20, 13,  2,
		41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
		44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32
	};

	typedef struct packed {
		logic [3:0]  rnd;
		logic [47:0] sk;
		logic        lst;
	} subkey_exp_t;

	subkey_exp_t expected_subkeys[$];
	int          n_fail = 0;

	assign fail_count  = n_fail;
	assign outstanding = expected_subkeys.size();

	// push all sixteen round subkeys of one key
	function automatic void expand_key(input logic [63:0] k);
		logic [55:0] cd;
		logic [27:0] c;
		logic [27:0] d;
		logic [55:0] joined;
		subkey_exp_t rec;
		for (int i = 0; i < 56; i++)
			cd[55-i] = k[64 - Pc1Pick[i]];
		c = cd[55:28];
		d = cd[27:0];
		for (int r = 0; r < Rounds; r++) begin
			if (r == 0 || r == 1 || r == 8 || r == Rounds - 1) begin
				c = {c[26:0], c[27]};
				d = {d[26:0], d[27]};
			end else begin
				c = {c[25:0], c[27:26]};
				d = {d[25:0], d[27:26]};
			end
			joined = {c, d};
			for (int i = 0; i < 48; i++)
				rec.sk[47-i] = joined[56 - Pc2Pick[i]];
			rec.rnd = 4'(r);
			rec.lst = (r == Rounds - 1);
			expected_subkeys.push_back(rec);
		end
	endfunction

	always @(posedge clk) begin
		subkey_exp_t exp_rec;
		if (arst_n) begin
			if (key_valid && !key_stall)
				expand_key(key);
			if (subkey_valid && !subkey_stall) begin
				if (expected_subkeys.size() == 0) begin
					n_fail++;
					if (n_fail <= MaxReports)
						$display("unexpected subkey transaction: round %0d subkey %h last %b",
							round_index, subkey, last);
				end else begin
					exp_rec = expected_subkeys.pop_front();
					if (round_index !== exp_rec.rnd || subkey !== exp_rec.sk ||
							last !== exp_rec.lst) begin
						n_fail++;
						if (n_fail <= MaxReports)
							$display("subkey mismatch: exp round %0d subkey %h last %b, got round %0d subkey %h last %b",
								exp_rec.rnd, exp_rec.sk, exp_rec.lst,
								round_index, subkey, last);
					end
				end
			end
		end
	end

endmodule

FILE: verif/des_key_schedule_tb.sv
`timescale 1ns / 100ps

module des_key_schedule_tb;

	localparam int CycleLimit  = 400000;
	localparam int RandomKeys  = 120;
	localparam int LongHold    = 300;
	localparam int DrainCycles = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        key_valid = 1'b0;
	logic        key_stall;
	logic [63:0] key = '0;
	logic        subkey_valid;
	logic        subkey_stall = 1'b0;
	logic [3:0]  round_index;
	logic [47:0] subkey;
	logic        last;

	int fail_count;
	int outstanding;
	int keys_sent = 0;
	int cycle_count = 0;
	bit held_long = 1'b0;

	des_key_schedule i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.key_valid   (key_valid),
		.key_stall   (key_stall),
		.key         (key),
		.subkey_valid(subkey_valid),
		.subkey_stall(subkey_stall),
		.round_index (round_index),
		.subkey      (subkey),
		.last        (last)
	);

	des_subkey_checker i_subkey_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.key_valid   (key_valid),
		.key_stall   (key_stall),
		.key         (key),
		.subkey_valid(subkey_valid),
		.subkey_stall(subkey_stall),
		.round_index (round_index),
		.subkey      (subkey),
		.last        (last),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 4);
		else
			return $urandom_range(10, 60);
	endfunction

	function automatic logic [63:0] random_key();
		int          r;
		logic [63:0] k;
		r = $urandom_range(0, 99);
		k = {$urandom, $urandom};
		if (r < 60)
			return k;
		else if (r < 75)
			return {8{k[7:0]}};
		else if (r < 85)
			// weak-key shapes with random parity bits
			return ($urandom_range(0, 1) ? 64'h0000000000000000 : 64'hfefefefefefefefe) ^
				(k & 64'h0101010101010101);
		else if (r < 93)
			return 64'h1 << $urandom_range(0, 63);
		else
			return ~(64'h1 << $urandom_range(0, 63));
	endfunction

	// called at a rising edge; returns at the edge where the key is taken
	task automatic offer_key(input logic [63:0] k, input int gap);
		if (gap > 0) begin
			key_valid <= 1'b0;
			key       <= {$urandom, $urandom};
			repeat (gap) @(posedge clk);
		end
		key_valid <= 1'b1;
		key       <= k;
		do @(posedge clk); while (key_stall);
		keys_sent++;
	endtask

	// one edge first so the checker has queued the last accepted key
	task automatic wait_drained();
		key_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// receiver: random stall runs, plus one long hold-off while keys keep coming
	initial begin
		int run;
		run = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held_long && keys_sent >= 30) begin
				held_long = 1'b1;
				subkey_stall <= 1'b1;
				repeat (LongHold) @(posedge clk);
				subkey_stall <= 1'b0;
				run = 0;
			end else if (run > 0) begin
				run--;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2: begin
						subkey_stall <= 1'b1;
						run = $urandom_range(0, 3);
					end
					3: begin
						subkey_stall <= 1'b1;
						run = $urandom_range(10, 40);
					end
					4: begin
						subkey_stall <= 1'b0;
						run = $urandom_range(30, 120);
					end
					default: begin
						subkey_stall <= 1'b0;
						run = $urandom_range(0, 6);
					end
				endcase
			end
		end
	end

	initial begin
		logic [63:0] directed [$];
		int          gap;

		directed = '{
			64'h0000000000000000, 64'hffffffffffffffff,
			64'h0101010101010101, 64'hfefefefefefefefe,
			64'h1f1f1f1f0e0e0e0e, 64'he0e0e0e0f1f1f1f1,
			64'h7f7f7f7f7f7f7f7f, 64'h133457799bbcdff1,
			64'h0123456789abcdef, 64'h8000000000000000,
			64'h0000000000000001, 64'haaaaaaaaaaaaaaaa,
			64'h5555555555555555, 64'h01fe01fe01fe01fe
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			offer_key(directed[i], (i % 3 == 0) ? 0 : pick_gap());
		wait_drained();

		for (int n = 0; n < RandomKeys; n++) begin
			// back to back around the long receiver hold-off so the block backs up
			if (keys_sent >= 28 && keys_sent <= 45)
				gap = 0;
			else
				gap = pick_gap();
			if (n == 70)
				wait_drained();
			offer_key(random_key(), gap);
		end

		wait_drained();
		repeat (DrainCycles) @(posedge clk);

		if (fail_count == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/desks_pkg.sv
hw/rtl/desks_round.sv
hw/rtl/des_key_schedule.sv
verif/des_subkey_checker.sv
verif/des_key_schedule_tb.sv
